/* rtl/core/jac_pkg.sv */
// Shared constants, types and codes of the joystick axis conditioner.
`timescale 1ns / 1ps
`default_nettype none

package jac_pkg;

  // Geometry of the block.
  localparam int STICKS  = 2;
  localparam int STICK_W = 1;

  // Converter samples and the normalized output format.
  localparam int ADC_BITS = 12;
  localparam int Q_BITS   = 15;
  localparam int POS_W    = Q_BITS + 1;
  localparam logic [ADC_BITS-1:0] ADC_MAX = {ADC_BITS{1'b1}};
  localparam logic [Q_BITS-1:0]   Q_ONE   = {Q_BITS{1'b1}};

  // Calibration accumulators.
  localparam int TOTAL_W = 20;
  localparam int COUNT_W = 9;
  localparam logic [COUNT_W-1:0] MAX_SAMPLES = COUNT_W'(256);
  localparam logic [COUNT_W-1:0] MIN_SAMPLES = COUNT_W'(1);

  // Shared divider: the widest dividend is the scaled remainder (mag - dz) * Q_ONE.
  localparam int DVD_W     = ADC_BITS + Q_BITS;
  localparam int DVS_W     = ADC_BITS;
  localparam int DIV_CNT_W = $clog2(DVD_W + 1);

  // Configuration port.
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 12;
  localparam int DZ_W       = 12;
  localparam int INV_W      = 4;

  localparam logic [CFG_IDX_W-1:0] REG_DEAD_ZONE     = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_CALIB_SAMPLES = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_INVERT_MASK   = 2'd2;

  localparam logic [DZ_W-1:0]    DEAD_ZONE_RST     = DZ_W'(100);
  localparam logic [COUNT_W-1:0] CALIB_SAMPLES_RST = COUNT_W'(32);
  localparam logic [INV_W-1:0]   INVERT_MASK_RST   = '0;

  // Item kinds.
  localparam logic KIND_CALIB = 1'b0;
  localparam logic KIND_READ  = 1'b1;

  // Per-lane sequencing strobes from the top level.
  typedef struct packed {
    logic prep;  // capture operands of the current beat
    logic load;  // start the lane divider
  } lane_ctrl_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_PREP,
    ST_LOAD,
    ST_DIV,
    ST_DONE
  } state_e;

endpackage

`default_nettype wire

/* rtl/core/jac_div.sv */
// Restoring radix-2 divider, one quotient bit per cycle.
`timescale 1ns / 1ps
`default_nettype none

module jac_div (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire logic                         load_i,
  input  wire logic [jac_pkg::DVD_W-1:0]    dividend_i,
  input  wire logic [jac_pkg::DVS_W-1:0]    divisor_i,
  output logic                              busy_o,
  output logic [jac_pkg::DVD_W-1:0]         quotient_o
);

  logic                             busy_q, busy_d;
  logic [jac_pkg::DIV_CNT_W-1:0]    cnt_q, cnt_d;
  logic [jac_pkg::DVS_W-1:0]        rem_q, rem_d;
  logic [jac_pkg::DVS_W-1:0]        dvs_q, dvs_d;
  logic [jac_pkg::DVD_W-1:0]        quo_q, quo_d;
  logic [jac_pkg::DVS_W:0]          trial;
  logic [jac_pkg::DVS_W:0]          diff;
  logic                             fits;

  // Bring down the next dividend bit and try the subtraction.
  assign trial = {rem_q, quo_q[jac_pkg::DVD_W-1]};
  assign diff  = trial - {1'b0, dvs_q};
  assign fits  = (trial >= {1'b0, dvs_q});

  always_comb begin
    busy_d = busy_q;
    cnt_d  = cnt_q;
    rem_d  = rem_q;
    dvs_d  = dvs_q;
    quo_d  = quo_q;
    if (load_i) begin
      busy_d = 1'b1;
      cnt_d  = jac_pkg::DIV_CNT_W'(jac_pkg::DVD_W);
      rem_d  = '0;
      dvs_d  = divisor_i;
      quo_d  = dividend_i;
    end else if (busy_q) begin
      rem_d  = fits ? diff[jac_pkg::DVS_W-1:0] : trial[jac_pkg::DVS_W-1:0];
      quo_d  = {quo_q[jac_pkg::DVD_W-2:0], fits};
      cnt_d  = cnt_q - jac_pkg::DIV_CNT_W'(1);
      busy_d = (cnt_q != jac_pkg::DIV_CNT_W'(1));
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    dvs_q <= dvs_d;
    quo_q <= quo_d;
  end

  assign busy_o     = busy_q;
  assign quotient_o = quo_q;

endmodule

`default_nettype wire

/* rtl/core/jac_lane.sv */
// One axis lane: center offset, dead zone, range and scaling through its own divider.
`timescale 1ns / 1ps
`default_nettype none

module jac_lane (
  input  wire logic                             clk_i,
  input  wire logic                             rst_ni,
  input  wire jac_pkg::lane_ctrl_t              ctrl_i,
  input  wire logic                             kind_i,
  input  wire logic [jac_pkg::ADC_BITS-1:0]     raw_i,
  input  wire logic [jac_pkg::ADC_BITS-1:0]     center_i,
  input  wire logic                             invert_i,
  input  wire logic [jac_pkg::DZ_W-1:0]         dead_zone_i,
  input  wire logic [jac_pkg::TOTAL_W-1:0]      total_i,
  input  wire logic [jac_pkg::COUNT_W-1:0]      count_i,
  output logic                                  busy_o,
  output logic signed [jac_pkg::POS_W-1:0]      position_o,
  output logic [jac_pkg::ADC_BITS-1:0]          average_o
);

  logic signed [jac_pkg::ADC_BITS:0] delta_raw, delta;
  logic                              neg;
  logic [jac_pkg::ADC_BITS-1:0]      mag, side;
  logic                              zero;

  logic                              kind_q;
  logic                              zero_q;
  logic                              neg_q;
  logic [jac_pkg::TOTAL_W-1:0]       base_q, base_d;
  logic [jac_pkg::DVS_W-1:0]         dvs_q, dvs_d;

  logic [jac_pkg::ADC_BITS-1:0]      num;
  logic [jac_pkg::DVD_W-1:0]         dividend;
  logic [jac_pkg::DVD_W-1:0]         quotient;
  logic [jac_pkg::POS_W-1:0]         q_clamped;

  // Signed offset from the center; inversion flips it before the side is chosen.
  assign delta_raw = $signed({1'b0, raw_i}) - $signed({1'b0, center_i});
  assign delta     = invert_i ? -delta_raw : delta_raw;
  assign neg       = delta[jac_pkg::ADC_BITS];
  assign mag       = neg ? jac_pkg::ADC_BITS'(-delta) : jac_pkg::ADC_BITS'(delta);
  assign side      = neg ? center_i : (jac_pkg::ADC_MAX - center_i);
  assign zero      = (mag <= dead_zone_i) || (side <= dead_zone_i);

  always_comb begin
    if (kind_i == jac_pkg::KIND_READ) begin
      base_d = jac_pkg::TOTAL_W'(mag - dead_zone_i);
      dvs_d  = side - dead_zone_i;
    end else begin
      base_d = total_i;
      dvs_d  = jac_pkg::DVS_W'(count_i);
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.prep) begin
      kind_q <= kind_i;
      zero_q <= zero;
      neg_q  <= neg;
      base_q <= base_d;
      dvs_q  <= dvs_d;
    end
  end

  // Times Q_ONE, which is one less than a power of two: shift and subtract.
  assign num = base_q[jac_pkg::ADC_BITS-1:0];
  assign dividend = (kind_q == jac_pkg::KIND_READ)
                  ? ({num, jac_pkg::Q_BITS'(0)} - jac_pkg::DVD_W'(num))
                  : jac_pkg::DVD_W'(base_q);

  jac_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .load_i     (ctrl_i.load),
    .dividend_i (dividend),
    .divisor_i  (dvs_q),
    .busy_o     (busy_o),
    .quotient_o (quotient)
  );

  assign q_clamped = (quotient > jac_pkg::DVD_W'(jac_pkg::Q_ONE))
                   ? jac_pkg::POS_W'(jac_pkg::Q_ONE)
                   : quotient[jac_pkg::POS_W-1:0];

  always_comb begin
    if (zero_q) begin
      position_o = '0;
    end else if (neg_q) begin
      position_o = $signed(-q_clamped);
    end else begin
      position_o = $signed(q_clamped);
    end
  end

  assign average_o = quotient[jac_pkg::ADC_BITS-1:0];

endmodule

`default_nettype wire

/* rtl/core/joystick_axis_conditioner.sv */
// Top level of the joystick axis conditioner: item capture, stick state, lanes and merge.
`timescale 1ns / 1ps
`default_nettype none

// Each accepted beat passes through operand preparation, divider load, the 27-step serial divider
// in each axis lane and the merge; no new beat is taken until that item is merged.
// A new input beat is accepted while the previous result still waits in the output register.
// Reset (rst_ni low, asynchronous) clears centers, totals, counts and button history and
// loads dead_zone = 100, calib_samples = 32, invert_mask = 0; no clearing pass is needed.
module joystick_axis_conditioner (
  input  wire logic                             clk_i,
  input  wire logic                             rst_ni,

  input  wire logic                             cfg_we_i,
  input  wire logic [jac_pkg::CFG_IDX_W-1:0]    cfg_index_i,
  input  wire logic [jac_pkg::CFG_DATA_W-1:0]   cfg_wdata_i,

  input  wire logic                             in_valid_i,
  output logic                                  in_ready_o,
  input  wire logic                             kind_i,
  input  wire logic [jac_pkg::STICK_W-1:0]      stick_i,
  input  wire logic [jac_pkg::ADC_BITS-1:0]     raw_x_i,
  input  wire logic [jac_pkg::ADC_BITS-1:0]     raw_y_i,
  input  wire logic                             button_level_i,

  output logic                                  out_valid_o,
  input  wire logic                             out_ready_i,
  output logic signed [jac_pkg::POS_W-1:0]      x_position_o,
  output logic signed [jac_pkg::POS_W-1:0]      y_position_o,
  output logic                                  btn_held_o,
  output logic                                  btn_press_o,
  output logic                                  btn_release_o,
  output logic [jac_pkg::ADC_BITS-1:0]          center_x_o,
  output logic [jac_pkg::ADC_BITS-1:0]          center_y_o,
  output logic                                  centers_updated_o
);

  // Configuration registers.
  logic [jac_pkg::DZ_W-1:0]     dead_zone_q;
  logic [jac_pkg::COUNT_W-1:0]  calib_samples_q;
  logic [jac_pkg::INV_W-1:0]    invert_mask_q;

  // Per-stick state: centers and totals per stick and axis, count and button history per stick.
  logic [jac_pkg::ADC_BITS-1:0] center_x_q [jac_pkg::STICKS];
  logic [jac_pkg::ADC_BITS-1:0] center_y_q [jac_pkg::STICKS];
  logic [jac_pkg::TOTAL_W-1:0]  total_x_q  [jac_pkg::STICKS];
  logic [jac_pkg::TOTAL_W-1:0]  total_y_q  [jac_pkg::STICKS];
  logic [jac_pkg::COUNT_W-1:0]  count_q    [jac_pkg::STICKS];
  logic                         last_down_q[jac_pkg::STICKS];

  // The accepted beat is held here for the whole computation.
  logic                         kind_q;
  logic [jac_pkg::STICK_W-1:0]  stick_q;
  logic [jac_pkg::ADC_BITS-1:0] raw_x_q, raw_y_q;
  logic                         level_q;
  logic                         complete_q;

  jac_pkg::state_e              state_q, state_d;
  jac_pkg::lane_ctrl_t          lane_ctrl;
  logic                         accept;
  logic                         out_load;

  logic [jac_pkg::TOTAL_W-1:0]  total_x_new, total_y_new;
  logic [jac_pkg::COUNT_W-1:0]  count_new, need;
  logic                         complete;
  logic                         inv_x, inv_y;

  logic                         x_busy, y_busy;
  logic signed [jac_pkg::POS_W-1:0] x_pos, y_pos;
  logic [jac_pkg::ADC_BITS-1:0] x_avg, y_avg;

  logic                         down;
  logic                         out_valid_q;

  assign accept = in_valid_i && in_ready_o;

  // ---------------------------------------------------------------------------
  // Configuration writes. An index past the last register is dropped.
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dead_zone_q     <= jac_pkg::DEAD_ZONE_RST;
      calib_samples_q <= jac_pkg::CALIB_SAMPLES_RST;
      invert_mask_q   <= jac_pkg::INVERT_MASK_RST;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        jac_pkg::REG_DEAD_ZONE:     dead_zone_q     <= cfg_wdata_i[jac_pkg::DZ_W-1:0];
        jac_pkg::REG_CALIB_SAMPLES: calib_samples_q <= cfg_wdata_i[jac_pkg::COUNT_W-1:0];
        jac_pkg::REG_INVERT_MASK:   invert_mask_q   <= cfg_wdata_i[jac_pkg::INV_W-1:0];
        default: ;
      endcase
    end
  end

  // ---------------------------------------------------------------------------
  // Sequencer: capture, prepare lane operands, start the dividers, wait, merge.
  // ---------------------------------------------------------------------------
  always_comb begin
    state_d = state_q;
    case (state_q)
      jac_pkg::ST_IDLE: if (accept) state_d = jac_pkg::ST_PREP;
      jac_pkg::ST_PREP: state_d = jac_pkg::ST_LOAD;
      jac_pkg::ST_LOAD: state_d = jac_pkg::ST_DIV;
      jac_pkg::ST_DIV:  if (!x_busy && !y_busy) state_d = jac_pkg::ST_DONE;
      jac_pkg::ST_DONE: if (out_load) state_d = jac_pkg::ST_IDLE;
      default:          state_d = jac_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    in_ready_o     = 1'b0;
    lane_ctrl.prep = 1'b0;
    lane_ctrl.load = 1'b0;
    out_load       = 1'b0;
    case (state_q)
      jac_pkg::ST_IDLE: in_ready_o     = 1'b1;
      jac_pkg::ST_PREP: lane_ctrl.prep = 1'b1;
      jac_pkg::ST_LOAD: lane_ctrl.load = 1'b1;
      jac_pkg::ST_DONE: out_load       = !out_valid_q || out_ready_i;
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= jac_pkg::ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      kind_q  <= kind_i;
      stick_q <= stick_i;
      raw_x_q <= raw_x_i;
      raw_y_q <= raw_y_i;
      level_q <= button_level_i;
    end
    if (lane_ctrl.prep) begin
      complete_q <= complete;
    end
  end

  // ---------------------------------------------------------------------------
  // Calibration bookkeeping. The sample target is clamped to one through 256;
  // a target lowered below the running count completes on the next sample.
  // ---------------------------------------------------------------------------
  always_comb begin
    if (calib_samples_q == '0) begin
      need = jac_pkg::MIN_SAMPLES;
    end else if (calib_samples_q > jac_pkg::MAX_SAMPLES) begin
      need = jac_pkg::MAX_SAMPLES;
    end else begin
      need = calib_samples_q;
    end
  end

  assign total_x_new = total_x_q[stick_q] + jac_pkg::TOTAL_W'(raw_x_q);
  assign total_y_new = total_y_q[stick_q] + jac_pkg::TOTAL_W'(raw_y_q);
  assign count_new   = count_q[stick_q] + jac_pkg::COUNT_W'(1);
  assign complete    = (count_new >= need);

  assign inv_x = invert_mask_q[{stick_q, 1'b0}];
  assign inv_y = invert_mask_q[{stick_q, 1'b1}];
  assign down  = !level_q;

  // Totals and counts move while the lanes are being prepared; centers and
  // button history move when the merged result enters the output register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < jac_pkg::STICKS; i++) begin
        center_x_q[i]  <= '0;
        center_y_q[i]  <= '0;
        total_x_q[i]   <= '0;
        total_y_q[i]   <= '0;
        count_q[i]     <= '0;
        last_down_q[i] <= 1'b0;
      end
    end else begin
      if (lane_ctrl.prep && (kind_q == jac_pkg::KIND_CALIB)) begin
        total_x_q[stick_q] <= complete ? '0 : total_x_new;
        total_y_q[stick_q] <= complete ? '0 : total_y_new;
        count_q[stick_q]   <= complete ? '0 : count_new;
      end
      if (out_load) begin
        if (kind_q == jac_pkg::KIND_READ) begin
          last_down_q[stick_q] <= down;
        end else if (complete_q) begin
          center_x_q[stick_q] <= x_avg;
          center_y_q[stick_q] <= y_avg;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Axis lanes. Both run the same number of divider steps and finish together.
  // ---------------------------------------------------------------------------
  jac_lane u_lane_x (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .ctrl_i      (lane_ctrl),
    .kind_i      (kind_q),
    .raw_i       (raw_x_q),
    .center_i    (center_x_q[stick_q]),
    .invert_i    (inv_x),
    .dead_zone_i (dead_zone_q),
    .total_i     (total_x_new),
    .count_i     (count_new),
    .busy_o      (x_busy),
    .position_o  (x_pos),
    .average_o   (x_avg)
  );

  jac_lane u_lane_y (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .ctrl_i      (lane_ctrl),
    .kind_i      (kind_q),
    .raw_i       (raw_y_q),
    .center_i    (center_y_q[stick_q]),
    .invert_i    (inv_y),
    .dead_zone_i (dead_zone_q),
    .total_i     (total_y_new),
    .count_i     (count_new),
    .busy_o      (y_busy),
    .position_o  (y_pos),
    .average_o   (y_avg)
  );

  // ---------------------------------------------------------------------------
  // Merge into the output register. Calibration beats report zero positions
  // and buttons, and the centers as they stand after the beat.
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_load) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      if (kind_q == jac_pkg::KIND_READ) begin
        x_position_o      <= x_pos;
        y_position_o      <= y_pos;
        btn_held_o        <= down;
        btn_press_o       <= down && !last_down_q[stick_q];
        btn_release_o     <= !down && last_down_q[stick_q];
        center_x_o        <= center_x_q[stick_q];
        center_y_o        <= center_y_q[stick_q];
        centers_updated_o <= 1'b0;
      end else begin
        x_position_o      <= '0;
        y_position_o      <= '0;
        btn_held_o        <= 1'b0;
        btn_press_o       <= 1'b0;
        btn_release_o     <= 1'b0;
        center_x_o        <= complete_q ? x_avg : center_x_q[stick_q];
        center_y_o        <= complete_q ? y_avg : center_y_q[stick_q];
        centers_updated_o <= complete_q;
      end
    end
  end

  assign out_valid_o = out_valid_q;

  // ---------------------------------------------------------------------------
  // Assertions.
  // ---------------------------------------------------------------------------
  a_lanes_in_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == jac_pkg::ST_DIV) |-> (x_busy == y_busy))
    else $error("axis lanes finished on different cycles");

  a_edge_exclusive: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> !(btn_press_o && btn_release_o))
    else $error("pressed and released reported together");

  a_pressed_down: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && btn_press_o) |-> btn_held_o)
    else $error("pressed reported without the button down");

  a_pos_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> ((x_position_o != 16'sh8000) && (y_position_o != 16'sh8000)))
    else $error("position outside of the clamped range");

endmodule

`default_nettype wire
